FILE: sv/lzw_variable_width_decoder_macros.svh
// Assertion helpers shared by the decoder RTL.
`ifndef LZW_VARIABLE_WIDTH_DECODER_MACROS_SVH
`define LZW_VARIABLE_WIDTH_DECODER_MACROS_SVH

// Condition holds at every edge outside reset.
`define LZWD_ASSERT(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// Consequence holds in the cycle after the antecedent.
`define LZWD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/lzwd_pkg.sv
package lzwd_pkg;

   localparam int START_CODE_BITS = 9;
   localparam int DICT_BASE       = 'h102;
   localparam int LITERAL_LIMIT   = 'h100;

   localparam logic CMD_PUSH = 1'b0;
   localparam logic CMD_PULL = 1'b1;

   localparam logic [1:0] STATUS_ACCEPTED = 2'd0;
   localparam logic [1:0] STATUS_REFUSED  = 2'd1;
   localparam logic [1:0] STATUS_OUTPUT   = 2'd2;
   localparam logic [1:0] STATUS_NONE     = 2'd3;

   typedef struct packed {
      logic       command;
      logic [7:0] compressed_byte;
      logic       end_of_stream;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      logic [7:0] out_byte;
      logic       string_end;
      logic       stream_end;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_PULL,
      ST_HEAD_WALK,
      ST_HEAD_WAIT,
      ST_INSERT,
      ST_STACK_START,
      ST_STACK_WAIT,
      ST_STACK_WALK,
      ST_FINISH
   } state_type;

endpackage

FILE: sv/lzw_variable_width_decoder.sv
// channel     | ports                                              | direction
// request     | push, full, req_command/compressed_byte/end_of_stream | in
// response    | empty, pop, rsp_status/out_byte/string_end/stream_end | out
//
// After reset the dictionary is zeroed one entry at a time; full stays high until it is done.
// A push that completes a code walks the dictionary links up to twice, once for the
// first-byte lookup and once to stack the string (single read port); a pull, a refused
// push or a push that completes no code walks no links.
// A two-entry request queue and a response register let either side stall freely.
module lzw_variable_width_decoder import lzwd_pkg::*; #(
   parameter int MAX_CODE_BITS = 12
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   output logic       full,
   input  logic       req_command,
   input  logic [7:0] req_compressed_byte,
   input  logic       req_end_of_stream,
   output logic       empty,
   input  logic       pop,
   output logic [1:0] rsp_status,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_string_end,
   output logic       rsp_stream_end
);

   req_type push_data, fifo_data;
   logic    fifo_full, fifo_empty, fifo_pop;
   logic    out_ready, out_valid, clearing;
   rsp_type out_res;
   rsp_type rsp_ff;
   logic    rsp_valid_ff, rsp_valid_in;

   assign push_data = '{command: req_command, compressed_byte: req_compressed_byte,
                        end_of_stream: req_end_of_stream};
   assign full = fifo_full || clearing;

   lzwd_req_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push && !clearing),
      .push_data (push_data),
      .full      (fifo_full),
      .pop       (fifo_pop),
      .empty     (fifo_empty),
      .pop_data  (fifo_data)
   );

   lzwd_engine #(.MAX_CODE_BITS(MAX_CODE_BITS)) u_engine (
      .clock     (clock),
      .reset     (reset),
      .req_valid (!fifo_empty),
      .req       (fifo_data),
      .req_pop   (fifo_pop),
      .out_ready (out_ready),
      .out_valid (out_valid),
      .out_res   (out_res),
      .clearing  (clearing)
   );

   always_comb begin
      out_ready    = !rsp_valid_ff || pop;
      rsp_valid_in = out_valid || (rsp_valid_ff && !pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_valid) begin
         rsp_ff <= out_res;
      end
   end

   assign empty          = !rsp_valid_ff;
   assign rsp_status     = rsp_ff.status;
   assign rsp_out_byte   = rsp_ff.out_byte;
   assign rsp_string_end = rsp_ff.string_end;
   assign rsp_stream_end = rsp_ff.stream_end;

endmodule

FILE: sv/lzwd_req_fifo.sv
module lzwd_req_fifo import lzwd_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  req_type push_data,
   output logic    full,
   input  logic    pop,
   output logic    empty,
   output req_type pop_data
);

   req_type    entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign full     = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);
   assign pop_data = entry_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: sv/lzwd_engine.sv
`include "lzw_variable_width_decoder_macros.svh"
module lzwd_engine import lzwd_pkg::*; #(
   parameter int MAX_CODE_BITS = 12
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  req_type req,
   output logic    req_pop,
   input  logic    out_ready,
   output logic    out_valid,
   output rsp_type out_res,
   output logic    clearing
);

   localparam int DEPTH = 1 << MAX_CODE_BITS;
   localparam int AW    = MAX_CODE_BITS;
   localparam int NW    = MAX_CODE_BITS + 1;
   localparam int LW    = MAX_CODE_BITS + 1;
   localparam int ACC_W = MAX_CODE_BITS + 7;
   localparam int BH_W  = $clog2(MAX_CODE_BITS + 8);
   localparam int CW_W  = $clog2(MAX_CODE_BITS + 2);

   logic [AW-1:0] prefix_mem [DEPTH];
   logic [7:0]    suffix_mem [DEPTH];
   logic [7:0]    stack_mem  [DEPTH];

   state_type      state_ff, state_in;
   logic [ACC_W-1:0] acc_ff, acc_in;
   logic [BH_W-1:0]  bits_ff, bits_in;
   logic [CW_W-1:0]  width_ff, width_in;
   logic [NW-1:0]    nfc_ff, nfc_in;
   logic             awaiting_ff, awaiting_in;
   logic [AW-1:0]    prev_ff, prev_in;
   logic [LW-1:0]    level_ff, level_in;
   logic             ending_ff, ending_in;
   logic [AW-1:0]    code_ff, code_in;
   logic [AW-1:0]    link_ff, link_in;
   logic [LW-1:0]    steps_ff, steps_in;
   logic [7:0]       first_ff, first_in;
   logic             eos_ff, eos_in;
   logic [AW-1:0]    clr_ff, clr_in;

   logic [AW-1:0] prefix_rd_ff;
   logic [7:0]    suffix_rd_ff;
   logic [7:0]    stack_rd_ff;

   logic          dict_we, dict_re, stack_we, stack_re;
   logic [AW-1:0] dict_waddr, dict_raddr, stack_waddr, stack_raddr;
   logic [AW-1:0] prefix_wdata;
   logic [7:0]    suffix_wdata, stack_wdata;

   logic             take;
   logic [ACC_W-1:0] acc_cat, shifted, acc_rest;
   logic [BH_W-1:0]  bits_sum, shift;
   logic             have_code;
   logic [AW-1:0]    code_mask, new_code;
   logic [NW-1:0]    nfc_p1, grow_limit;
   logic [CW_W-1:0]  width_p1;
   logic             walk_more, stack_more, link_is_chain;

   always_comb begin
      take      = req_valid && out_ready;
      acc_cat   = {acc_ff[ACC_W-9:0], req.compressed_byte};
      bits_sum  = bits_ff + BH_W'(8);
      have_code = (bits_sum >= BH_W'(width_ff));
      shift     = bits_sum - BH_W'(width_ff);
      shifted   = acc_cat >> shift;
      code_mask = ~({AW{1'b1}} << width_ff);
      new_code  = shifted[AW-1:0] & code_mask;
      acc_rest  = acc_cat & ~({ACC_W{1'b1}} << shift);
      nfc_p1     = nfc_ff + NW'(1);
      grow_limit = (NW'(1) << width_ff) - NW'(1);
      width_p1   = width_ff + CW_W'(1);
      link_is_chain = (link_ff > AW'(LITERAL_LIMIT));
      walk_more  = link_is_chain && (steps_ff < LW'(DEPTH - 1));
      stack_more = link_is_chain && (level_ff < LW'(DEPTH - 1));
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == AW'(DEPTH - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (take) begin
               if (req.command == CMD_PULL) begin
                  state_in = (level_ff == '0) ? ST_IDLE : ST_PULL;
               end else if (level_ff != '0) begin
                  state_in = ST_IDLE;
               end else if (!have_code) begin
                  state_in = ST_FINISH;
               end else if (awaiting_ff) begin
                  state_in = ST_STACK_START;
               end else if (new_code < AW'(LITERAL_LIMIT)) begin
                  state_in = ST_INSERT;
               end else if ({1'b0, new_code} < nfc_ff) begin
                  state_in = ST_HEAD_WAIT;
               end else begin
                  state_in = ST_HEAD_WALK;
               end
            end
         end
         ST_PULL:        state_in = out_ready ? ST_IDLE : ST_PULL;
         ST_HEAD_WALK:   state_in = walk_more ? ST_HEAD_WAIT : ST_INSERT;
         ST_HEAD_WAIT:   state_in = ST_HEAD_WALK;
         ST_INSERT:      state_in = ST_STACK_START;
         ST_STACK_START: state_in = (code_ff < AW'(LITERAL_LIMIT)) ? ST_FINISH : ST_STACK_WAIT;
         ST_STACK_WAIT:  state_in = ST_STACK_WALK;
         ST_STACK_WALK:  state_in = stack_more ? ST_STACK_WAIT : ST_FINISH;
         ST_FINISH:      state_in = out_ready ? ST_IDLE : ST_FINISH;
         default:        state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      acc_in      = acc_ff;
      bits_in     = bits_ff;
      width_in    = width_ff;
      nfc_in      = nfc_ff;
      awaiting_in = awaiting_ff;
      prev_in     = prev_ff;
      level_in    = level_ff;
      ending_in   = ending_ff;
      code_in     = code_ff;
      link_in     = link_ff;
      steps_in    = steps_ff;
      first_in    = first_ff;
      eos_in      = eos_ff;
      clr_in      = clr_ff;
      dict_we      = 1'b0;
      dict_waddr   = nfc_ff[AW-1:0];
      prefix_wdata = prev_ff;
      suffix_wdata = first_ff;
      dict_re      = 1'b0;
      dict_raddr   = link_ff;
      stack_we     = 1'b0;
      stack_waddr  = level_ff[AW-1:0];
      stack_wdata  = suffix_rd_ff;
      stack_re     = 1'b0;
      stack_raddr  = level_in[AW-1:0];
      req_pop   = 1'b0;
      out_valid = 1'b0;
      out_res   = '0;
      clearing  = (state_ff == ST_CLEAR);
      unique case (state_ff)
         ST_CLEAR: begin
            dict_we      = 1'b1;
            dict_waddr   = clr_ff;
            prefix_wdata = '0;
            suffix_wdata = '0;
            clr_in       = clr_ff + AW'(1);
         end
         ST_IDLE: begin
            if (take) begin
               req_pop = 1'b1;
               if (req.command == CMD_PULL) begin
                  if (level_ff == '0) begin
                     out_valid      = 1'b1;
                     out_res.status = STATUS_NONE;
                  end else begin
                     level_in    = level_ff - LW'(1);
                     stack_re    = 1'b1;
                     stack_raddr = level_in[AW-1:0];
                  end
               end else if (level_ff != '0) begin
                  out_valid      = 1'b1;
                  out_res.status = STATUS_REFUSED;
               end else begin
                  eos_in  = req.end_of_stream;
                  acc_in  = have_code ? acc_rest : acc_cat;
                  bits_in = have_code ? shift : bits_sum;
                  code_in = new_code;
                  steps_in = '0;
                  first_in = new_code[7:0];
                  link_in  = prev_ff;
                  dict_re    = have_code && !awaiting_ff;
                  dict_raddr = new_code;
               end
            end
         end
         ST_PULL: begin
            if (out_ready) begin
               out_valid        = 1'b1;
               out_res.status   = STATUS_OUTPUT;
               out_res.out_byte = stack_rd_ff;
               if (level_ff == '0) begin
                  out_res.string_end = 1'b1;
                  out_res.stream_end = ending_ff;
                  ending_in          = 1'b0;
               end
            end
         end
         ST_HEAD_WALK: begin
            if (walk_more) begin
               dict_re    = 1'b1;
               dict_raddr = link_ff;
               steps_in   = steps_ff + LW'(1);
            end else begin
               first_in = link_ff[7:0];
            end
         end
         ST_HEAD_WAIT: begin
            link_in = prefix_rd_ff;
         end
         ST_INSERT: begin
            dict_we = 1'b1;
            if (nfc_p1 >= NW'(DEPTH)) begin
               nfc_in   = NW'(DICT_BASE);
               width_in = CW_W'(START_CODE_BITS);
            end else begin
               nfc_in = nfc_p1;
               if (nfc_p1 == grow_limit) begin
                  width_in = (width_p1 == CW_W'(MAX_CODE_BITS + 1)) ?
                             CW_W'(START_CODE_BITS) : width_p1;
               end
            end
         end
         ST_STACK_START: begin
            awaiting_in = 1'b0;
            prev_in     = code_ff;
            if (code_ff < AW'(LITERAL_LIMIT)) begin
               stack_we    = 1'b1;
               stack_waddr = '0;
               stack_wdata = code_ff[7:0];
               level_in    = LW'(1);
            end else begin
               level_in   = '0;
               dict_re    = 1'b1;
               dict_raddr = code_ff;
            end
         end
         ST_STACK_WAIT: begin
            stack_we    = 1'b1;
            stack_wdata = suffix_rd_ff;
            level_in    = level_ff + LW'(1);
            link_in     = prefix_rd_ff;
         end
         ST_STACK_WALK: begin
            if (stack_more) begin
               dict_re    = 1'b1;
               dict_raddr = link_ff;
            end else begin
               stack_we    = 1'b1;
               stack_wdata = link_ff[7:0];
               level_in    = level_ff + LW'(1);
            end
         end
         ST_FINISH: begin
            if (out_ready) begin
               out_valid      = 1'b1;
               out_res.status = STATUS_ACCEPTED;
               if (eos_ff) begin
                  acc_in      = '0;
                  bits_in     = '0;
                  awaiting_in = 1'b1;
                  nfc_in      = NW'(DICT_BASE);
                  width_in    = CW_W'(START_CODE_BITS);
                  ending_in   = (level_ff != '0);
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CLEAR;
         acc_ff      <= '0;
         bits_ff     <= '0;
         width_ff    <= CW_W'(START_CODE_BITS);
         nfc_ff      <= NW'(DICT_BASE);
         awaiting_ff <= 1'b1;
         prev_ff     <= '0;
         level_ff    <= '0;
         ending_ff   <= 1'b0;
         clr_ff      <= '0;
      end else begin
         state_ff    <= state_in;
         acc_ff      <= acc_in;
         bits_ff     <= bits_in;
         width_ff    <= width_in;
         nfc_ff      <= nfc_in;
         awaiting_ff <= awaiting_in;
         prev_ff     <= prev_in;
         level_ff    <= level_in;
         ending_ff   <= ending_in;
         clr_ff      <= clr_in;
      end
   end

   always_ff @(posedge clock) begin
      code_ff  <= code_in;
      link_ff  <= link_in;
      steps_ff <= steps_in;
      first_ff <= first_in;
      eos_ff   <= eos_in;
   end

   always_ff @(posedge clock) begin
      if (dict_we) begin
         prefix_mem[dict_waddr] <= prefix_wdata;
         suffix_mem[dict_waddr] <= suffix_wdata;
      end
      if (dict_re) begin
         prefix_rd_ff <= prefix_mem[dict_raddr];
         suffix_rd_ff <= suffix_mem[dict_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (stack_we) begin
         stack_mem[stack_waddr] <= stack_wdata;
      end
      if (stack_re) begin
         stack_rd_ff <= stack_mem[stack_raddr];
      end
   end

   `LZWD_ASSERT(a_level_range, level_ff <= LW'(DEPTH), "stack level beyond depth")
   `LZWD_ASSERT(a_nfc_range, (nfc_ff >= NW'(DICT_BASE)) && (nfc_ff < NW'(DEPTH)), "free code out of range")
   `LZWD_ASSERT(a_width_range, (width_ff >= CW_W'(START_CODE_BITS)) && (width_ff <= CW_W'(MAX_CODE_BITS)), "code width out of range")
   `LZWD_ASSERT_NEXT(a_insert_moves, state_ff == ST_INSERT, nfc_ff != $past(nfc_ff), "insert left free code unchanged")
   `LZWD_ASSERT(a_clear_quiet, !(clearing && (out_valid || req_pop)), "request handled during clear")

endmodule

FILE: tb/sv/tb_lzw_variable_width_decoder.sv
`timescale 1ns / 1ps

module tb_lzw_variable_width_decoder;
   import lzwd_pkg::*;

   localparam int DICT_BITS  = 12;
   localparam int DICT_DEPTH = 1 << DICT_BITS;
   localparam int IDLE_LIMIT = 60000;
   localparam int RANDOM_REQUESTS = 100;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       push = 1'b0;
   logic       full;
   logic       req_command = CMD_PUSH;
   logic [7:0] req_compressed_byte = 8'd0;
   logic       req_end_of_stream = 1'b0;
   logic       empty;
   logic       pop = 1'b0;
   logic [1:0] rsp_status;
   logic [7:0] rsp_out_byte;
   logic       rsp_string_end;
   logic       rsp_stream_end;

   lzw_variable_width_decoder #(.MAX_CODE_BITS(DICT_BITS)) DUT (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // decoder state mirror
   logic [11:0] dict_prefix [DICT_DEPTH];
   logic [7:0]  dict_suffix [DICT_DEPTH];
   logic [7:0]  out_stack [DICT_DEPTH];
   int          free_code, code_bits, bits_held, prev_code, stack_depth;
   logic [31:0] bit_acc;
   bit          first_code, stream_ending;

   rsp_type expected_rsps[$];
   int      errors = 0;
   int      requests = 0;
   int      responses = 0;
   int      decoded_bytes = 0;
   int      streams = 0;
   bit      calm = 1'b0;
   int      hold_request = 0;
   int      rx_idle = 0;
   int      idle_cycles = 0;

   function automatic logic [7:0] head_byte(int link);
      int steps;
      steps = 0;
      link &= DICT_DEPTH - 1;
      while (link > LITERAL_LIMIT && steps < DICT_DEPTH - 1) begin
         link = int'(dict_prefix[link]);
         steps++;
      end
      return link[7:0];
   endfunction

   function automatic void stack_code(int code);
      int link;
      code &= DICT_DEPTH - 1;
      stack_depth = 0;
      if (code < LITERAL_LIMIT) begin
         out_stack[stack_depth++] = code[7:0];
         return;
      end
      out_stack[stack_depth++] = dict_suffix[code];
      link = int'(dict_prefix[code]);
      while (link > LITERAL_LIMIT && stack_depth < DICT_DEPTH - 1) begin
         out_stack[stack_depth++] = dict_suffix[link];
         link = int'(dict_prefix[link]);
      end
      out_stack[stack_depth++] = link[7:0];
   endfunction

   function automatic void decode_code(int code);
      logic [7:0] first;
      if (first_code) begin
         first_code = 1'b0;
         stack_code(code);
         prev_code = code;
         return;
      end
      if (code < LITERAL_LIMIT) first = code[7:0];
      else if (code < free_code) first = head_byte(int'(dict_prefix[code]));
      else first = head_byte(prev_code);
      dict_prefix[free_code & (DICT_DEPTH - 1)] = prev_code[11:0];
      dict_suffix[free_code & (DICT_DEPTH - 1)] = first;
      free_code++;
      if (free_code == (1 << code_bits) - 1) begin
         code_bits++;
         if (code_bits == DICT_BITS + 1) code_bits = START_CODE_BITS;
      end
      if (free_code >= DICT_DEPTH) begin
         free_code = DICT_BASE;
         code_bits = START_CODE_BITS;
      end
      stack_code(code);
      prev_code = code;
   endfunction

   function automatic rsp_type predict_rsp(req_type r);
      rsp_type o;
      int shift, code;
      o = '0;
      if (r.command == CMD_PULL) begin
         if (stack_depth == 0) begin
            o.status = STATUS_NONE;
            return o;
         end
         stack_depth--;
         o.status = STATUS_OUTPUT;
         o.out_byte = out_stack[stack_depth];
         if (stack_depth == 0) begin
            o.string_end = 1'b1;
            o.stream_end = stream_ending;
            stream_ending = 1'b0;
         end
         return o;
      end
      if (stack_depth != 0) begin
         o.status = STATUS_REFUSED;
         return o;
      end
      bit_acc = (bit_acc << 8) | r.compressed_byte;
      bits_held += 8;
      if (bits_held >= code_bits) begin
         shift = bits_held - code_bits;
         code = (bit_acc >> shift) & ((1 << code_bits) - 1);
         bits_held = shift;
         bit_acc &= (32'd1 << bits_held) - 1;
         decode_code(code);
      end
      if (r.end_of_stream) begin
         bit_acc = 0;
         bits_held = 0;
         first_code = 1'b1;
         free_code = DICT_BASE;
         code_bits = START_CODE_BITS;
         stream_ending = (stack_depth != 0);
      end
      o.status = STATUS_ACCEPTED;
      return o;
   endfunction

   function automatic int pick_gap();
      int r;
      if (calm) return 0;
      r = $urandom_range(99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic send_request(logic cmd, logic [7:0] data, logic eos);
      req_type r;
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      push <= 1'b1;
      req_command <= cmd;
      req_compressed_byte <= data;
      req_end_of_stream <= eos;
      do @(posedge clock); while (full);
      r.command = cmd;
      r.compressed_byte = data;
      r.end_of_stream = eos;
      expected_rsps.push_back(predict_rsp(r));
      requests++;
   endtask

   // stop offering and wait until every expected response has come back
   task automatic pause_until_drained();
      push <= 1'b0;
      @(posedge clock);
      wait (expected_rsps.size() == 0);
   endtask

   task automatic send_noise();
      send_request(1'($urandom_range(1)), 8'($urandom_range(255)), $urandom_range(9) == 0);
   endtask

   task automatic drain_output(int noise_pct);
      while (stack_depth != 0) begin
         if ($urandom_range(99) < noise_pct)
            send_request(CMD_PUSH, 8'($urandom_range(255)), 1'($urandom_range(1)));
         else
            send_request(CMD_PULL, 8'd0, 1'b0);
      end
   endtask

   // pack codes MSB first at the growing width and push them as one stream, possibly cut short
   task automatic send_codes(int codes[$], int noise_pct, bit cut_short);
      bit bits_q[$];
      int nf, w, cut;
      logic [7:0] b;
      nf = DICT_BASE;
      w = START_CODE_BITS;
      foreach (codes[i]) begin
         for (int k = w - 1; k >= 0; k--) bits_q.push_back(codes[i][k]);
         if (i > 0) begin
            nf++;
            if (nf == (1 << w) - 1) begin
               w++;
               if (w == DICT_BITS + 1) w = START_CODE_BITS;
            end
            if (nf >= DICT_DEPTH) begin
               nf = DICT_BASE;
               w = START_CODE_BITS;
            end
         end
      end
      while (bits_q.size() % 8 != 0) bits_q.push_back(1'($urandom_range(1)));
      cut = cut_short ? $urandom_range(1, bits_q.size() / 8) : bits_q.size() / 8;
      for (int n = 0; n < cut; n++) begin
         if ($urandom_range(99) < noise_pct) begin
            send_noise();
            drain_output(noise_pct);
         end
         for (int k = 0; k < 8; k++) b[7 - k] = bits_q[n * 8 + k];
         send_request(CMD_PUSH, b, n == cut - 1);
         drain_output(noise_pct);
      end
      streams++;
   endtask

   function automatic void make_codes(ref int codes[$], input int count, input int lit_pct);
      int nf, r;
      nf = DICT_BASE;
      codes.delete();
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(99);
         if (i == 0 || r < lit_pct) codes.push_back($urandom_range(255));
         else if (r < lit_pct + 3) codes.push_back(LITERAL_LIMIT + $urandom_range(1));
         else if (nf > DICT_BASE && r < 92) codes.push_back($urandom_range(DICT_BASE, nf - 1));
         else codes.push_back(nf);
         if (i > 0) nf = (nf + 1 >= DICT_DEPTH) ? DICT_BASE : nf + 1;
      end
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch on response %0d: %s got %0h expected %0h", responses, what, got, want);
      errors++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         pop <= 1'b0;
      end else if (hold_request != 0) begin
         rx_idle <= hold_request;
         hold_request = 0;
         pop <= 1'b0;
      end else if (pop && !empty) begin
         rx_idle <= pick_gap();
         pop <= (pick_gap() == 0);
      end else if (rx_idle > 0) begin
         rx_idle <= rx_idle - 1;
         pop <= 1'b0;
      end else begin
         pop <= 1'b1;
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && pop && !empty) begin
         if (expected_rsps.size() == 0) begin
            $display("response %0d arrived with no request waiting", responses);
            errors++;
         end else begin
            want = expected_rsps.pop_front();
            if (rsp_status != want.status)
               report_mismatch("status", int'(rsp_status), int'(want.status));
            if (rsp_out_byte != want.out_byte)
               report_mismatch("out_byte", int'(rsp_out_byte), int'(want.out_byte));
            if (rsp_string_end != want.string_end)
               report_mismatch("string_end", int'(rsp_string_end), int'(want.string_end));
            if (rsp_stream_end != want.stream_end)
               report_mismatch("stream_end", int'(rsp_stream_end), int'(want.stream_end));
            if (want.status == STATUS_OUTPUT) decoded_bytes++;
         end
         responses++;
      end
   end

   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no request or response moved for %0d cycles", IDLE_LIMIT);
            $display("lzw_variable_width_decoder test failed");
            $finish;
         end
      end
   end

   task automatic test_empty_pull();
      send_request(CMD_PULL, 8'd0, 1'b0);
      send_request(CMD_PULL, 8'd0, 1'b1);
   endtask

   task automatic test_directed_stream();
      int codes[$];
      // literals at both ends, dictionary hit, KwKwK, reserved, beyond free
      codes = '{8'h00, 8'hFF, 'h102, 'h104, 'h101, 'h1FF};
      send_codes(codes, 0, 1'b0);
      codes = '{'h100, 8'h41, 'h103};
      send_codes(codes, 0, 1'b0);
   endtask

   task automatic test_refused_and_padding();
      send_request(CMD_PUSH, 8'hFF, 1'b1);
      send_request(CMD_PUSH, 8'h20, 1'b0);
      send_request(CMD_PUSH, 8'h80, 1'b0);
      send_request(CMD_PUSH, 8'h55, 1'b0);
      send_request(CMD_PULL, 8'd0, 1'b0);
      send_request(CMD_PULL, 8'd0, 1'b0);
      send_request(CMD_PUSH, 8'hAA, 1'b1);
      drain_output(0);
   endtask

   task automatic test_width_growth();
      int codes[$];
      make_codes(codes, 260, 93);
      send_codes(codes, 0, 1'b0);
   endtask

   task automatic test_backpressure();
      pause_until_drained();
      calm = 1'b1;
      hold_request = 300;
      repeat (12) send_noise();
      calm = 1'b0;
      drain_output(0);
      pause_until_drained();
   endtask

   task automatic test_random_streams();
      int codes[$];
      int target;
      target = requests + RANDOM_REQUESTS;
      while (requests < target) begin
         calm = ($urandom_range(4) == 0);
         make_codes(codes, $urandom_range(2, 40), $urandom_range(30, 80));
         send_codes(codes, ($urandom_range(3) == 0) ? 15 : 0, $urandom_range(7) == 0);
         if ($urandom_range(5) == 0) pause_until_drained();
      end
      calm = 1'b0;
   endtask

   initial begin
      for (int i = 0; i < DICT_DEPTH; i++) begin
         dict_prefix[i] = '0;
         dict_suffix[i] = '0;
         out_stack[i] = '0;
      end
      free_code = DICT_BASE;
      code_bits = START_CODE_BITS;
      bits_held = 0;
      bit_acc = '0;
      prev_code = 0;
      stack_depth = 0;
      first_code = 1'b1;
      stream_ending = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_pull();
      test_directed_stream();
      test_refused_and_padding();
      test_backpressure();
      test_width_growth();
      test_random_streams();

      pause_until_drained();
      repeat (50) @(posedge clock);
      $display("covered %0d requests over %0d code streams, %0d decoded bytes checked",
               requests, streams, decoded_bytes);
      $display("including code width growth, refused pushes and a long output stall");
      if (errors == 0 && expected_rsps.size() == 0) begin
         $display("lzw_variable_width_decoder test passed");
      end else begin
         $display("lzw_variable_width_decoder test failed");
      end
      $finish;
   end

endmodule
